/* design/cnia_pkg.sv */
// Package for the CAN node-ID allocatee block: payload structs, phase and
// code enums, configuration register indexes and fixed protocol constants.
// No dependencies.
`timescale 1ns / 1ps

package cnia_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_NODE_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_NODE_ID = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_UID_HASH      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DISC_ID       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DISC_LEN      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ASGN_ID       = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_ASGN_LEN      = 3'd6;

  localparam int unsigned CfgDataW = 48;

  // Broadcast node ID, never usable as an own ID
  localparam logic [4:0] BROADCAST_ID = 5'd31;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_START    = 2'd1,
    KIND_DISCOVER = 2'd2,
    KIND_ASSIGN   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_REASSIGN = 2'd0,
    MODE_FIXED    = 2'd1,
    MODE_RSVD2    = 2'd2,
    MODE_RSVD3    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FRAME_NONE      = 2'd0,
    FRAME_ADVERTISE = 2'd1,
    FRAME_ACK       = 2'd2
  } frame_e;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_AWAIT_DISC   = 3'd1,
    PH_DISC_STARTED = 3'd2,
    PH_ADVERTISE    = 3'd3,
    PH_AWAIT_ASSIGN = 3'd4,
    PH_ASSIGNED     = 3'd5,
    PH_ACK          = 3'd6
  } phase_e;

  // One input item
  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  rx_session;
    logic [47:0] rx_uid;
    logic [15:0] rx_offer_id;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic        accepted;
    logic [1:0]  frame_out;
    logic [4:0]  out_node_id;
    logic [47:0] out_uid;
    logic [7:0]  out_session;
    logic        out_mode;
    logic        assigned_done;
    logic [2:0]  phase_now;
  } out_item_t;

  // Configuration registers as seen by the step logic
  typedef struct packed {
    logic [1:0]  node_mode;
    logic [4:0]  start_node_id;
    logic [47:0] uid_hash;
    logic [10:0] disc_id;
    logic [3:0]  disc_len;
    logic [10:0] asgn_id;
    logic [3:0]  asgn_len;
  } cfg_t;

  // Handshake state carried from item to item
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  session;
    logic [4:0]  held_node;
    logic        fixed_mode;
  } state_t;

endpackage

/* design/cnia_step.sv */
// Combinational step of the node-ID allocatee handshake: one item plus the
// current state gives the next state and the result item.
// Depends on cnia_pkg.
`timescale 1ns / 1ps

module cnia_step #(
  parameter int unsigned MAX_NODE_ID = 30
) (
  input  cnia_pkg::in_item_t  item_i,
  input  cnia_pkg::cfg_t      cfg_i,
  input  cnia_pkg::state_t    state_i,
  output cnia_pkg::state_t    state_o,
  output cnia_pkg::out_item_t result_o
);
  import cnia_pkg::*;

  logic start_ok;
  logic disc_ok;
  logic asgn_ok;

  // Start: mode not reserved, ID in range and not broadcast, fixed needs an ID
  assign start_ok = ((cfg_i.node_mode == MODE_REASSIGN) || (cfg_i.node_mode == MODE_FIXED))
                 && ({3'b000, cfg_i.start_node_id} <= 8'(MAX_NODE_ID))
                 && (cfg_i.start_node_id != BROADCAST_ID)
                 && !((cfg_i.node_mode == MODE_FIXED) && (cfg_i.start_node_id == 5'd0));

  // Discover frame header match while waiting for discovery
  assign disc_ok = (state_i.phase == PH_AWAIT_DISC)
                && (item_i.frame_id == cfg_i.disc_id)
                && (item_i.frame_len == cfg_i.disc_len);

  // Assign frame, reassign mode only: header, UID, session and offered ID all have to fit
  assign asgn_ok = (state_i.phase == PH_AWAIT_ASSIGN) && !state_i.fixed_mode
                && (item_i.frame_id == cfg_i.asgn_id)
                && (item_i.frame_len == cfg_i.asgn_len)
                && (item_i.rx_uid == cfg_i.uid_hash)
                && (item_i.rx_session == state_i.session)
                && (item_i.rx_offer_id != 16'd0)
                && (item_i.rx_offer_id <= 16'(MAX_NODE_ID))
                && (item_i.rx_offer_id < {11'd0, BROADCAST_ID});

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (item_i.kind)
      KIND_START: begin
        if (start_ok) begin
          state_o.fixed_mode = (cfg_i.node_mode == MODE_FIXED);
          state_o.held_node  = cfg_i.start_node_id;
          state_o.session    = 8'd0;
          state_o.phase      = PH_AWAIT_DISC;
          result_o.accepted  = 1'b1;
        end
      end
      KIND_DISCOVER: begin
        if (disc_ok) begin
          state_o.session   = item_i.rx_session;
          state_o.phase     = PH_DISC_STARTED;
          result_o.accepted = 1'b1;
        end
      end
      KIND_ASSIGN: begin
        if (asgn_ok) begin
          state_o.held_node = item_i.rx_offer_id[4:0];
          state_o.phase     = PH_ASSIGNED;
          result_o.accepted = 1'b1;
        end
      end
      default: begin
        // tick: advance the timed phases, send frames
        case (state_i.phase)
          PH_DISC_STARTED: state_o.phase = PH_ADVERTISE;
          PH_ADVERTISE: begin
            result_o.frame_out   = FRAME_ADVERTISE;
            result_o.out_node_id = state_i.held_node;
            result_o.out_uid     = cfg_i.uid_hash;
            result_o.out_session = state_i.session;
            result_o.out_mode    = state_i.fixed_mode;
            state_o.phase        = state_i.fixed_mode ? PH_AWAIT_DISC : PH_AWAIT_ASSIGN;
          end
          PH_ASSIGNED: state_o.phase = PH_ACK;
          PH_ACK: begin
            result_o.frame_out     = FRAME_ACK;
            result_o.out_node_id   = state_i.held_node;
            result_o.out_uid       = cfg_i.uid_hash;
            result_o.out_session   = state_i.session;
            result_o.assigned_done = 1'b1;
            state_o.phase          = PH_AWAIT_DISC;
          end
          default: ;
        endcase
      end
    endcase
    result_o.phase_now = state_o.phase;
  end

endmodule

/* design/can_node_id_allocatee_fsm.sv */
// Top level of the CAN node-ID allocatee: input register, handshake state,
// configuration registers and result register. Depends on cnia_pkg, cnia_step.
`timescale 1ns / 1ps

// Node side of the bus node-ID allocation handshake. Every accepted item
// (tick, start, discover frame, assign frame) gives exactly one result item,
// shown on the outputs once it reaches the result register: the item is
// captured in an input register, the step logic works on it and the result is
// captured in the result register. One item per cycle is taken in steady state
// while results are not stalled; the input register and the result register
// each hold one item, so while a result is stalled one more item is still
// taken before the input stalls. Configuration writes are always ready and take
// effect on the next cycle; write them only while no item is in flight.
module can_node_id_allocatee_fsm #(
  parameter int unsigned MAX_NODE_ID = 30
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cnia_pkg::in_item_t                in_data_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cnia_pkg::out_item_t               out_data_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cnia_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [cnia_pkg::CfgDataW-1:0]     cfg_data_i
);
  import cnia_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  cfg_t      cfg_q;
  state_t    state_q;
  state_t    state_d;
  out_item_t result_d;
  logic      advance;
  logic      in_take;

  // Input register moves on when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  cnia_step #(
    .MAX_NODE_ID (MAX_NODE_ID)
  ) u_step (
    .item_i   (in_item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Control state, handshake state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q       <= '0;
      state_q     <= '{phase: PH_IDLE, session: 8'd0, held_node: 5'd0, fixed_mode: 1'b0};
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_NODE_MODE:     cfg_q.node_mode     <= cfg_data_i[1:0];
          CFG_START_NODE_ID: cfg_q.start_node_id <= cfg_data_i[4:0];
          CFG_UID_HASH:      cfg_q.uid_hash      <= cfg_data_i[47:0];
          CFG_DISC_ID:       cfg_q.disc_id       <= cfg_data_i[10:0];
          CFG_DISC_LEN:      cfg_q.disc_len      <= cfg_data_i[3:0];
          CFG_ASGN_ID:       cfg_q.asgn_id       <= cfg_data_i[10:0];
          CFG_ASGN_LEN:      cfg_q.asgn_len      <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q <= result_d;
    end
  end

endmodule

/* design/cnia_checker.sv */
// Port-level checks for can_node_id_allocatee_fsm and the bind that attaches
// them. Depends on cnia_pkg.
`timescale 1ns / 1ps

module cnia_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cnia_pkg::out_item_t out_data_o
);
  import cnia_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // No frame sent: frame contents are all zero
  a_quiet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.frame_out == FRAME_NONE) |->
      (out_data_o.out_node_id == 5'd0) && (out_data_o.out_uid == 48'd0)
      && (out_data_o.out_session == 8'd0) && !out_data_o.out_mode
      && !out_data_o.assigned_done)
    else $error("frame fields set with nothing sent");

  // Done pulses with the acknowledge, which returns to await discovery
  a_ack_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.assigned_done == (out_data_o.frame_out == FRAME_ACK))
      && ((out_data_o.frame_out != FRAME_ACK)
          || ((out_data_o.phase_now == PH_AWAIT_DISC) && !out_data_o.out_mode)))
    else $error("acknowledge result inconsistent");

  // Advertise only from a tick, and leads to the matching wait phase
  a_adv_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.frame_out == FRAME_ADVERTISE) |->
      !out_data_o.accepted
      && ((out_data_o.out_mode && (out_data_o.phase_now == PH_AWAIT_DISC))
          || (!out_data_o.out_mode && (out_data_o.phase_now == PH_AWAIT_ASSIGN))))
    else $error("advertise result inconsistent");

endmodule

bind can_node_id_allocatee_fsm cnia_checker u_cnia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
